[hdl/checkpoint_ring_log_assert.svh]
// Assertion macros for the checkpoint ring log.
// Included by the top level; needs no other file.
`ifndef CHECKPOINT_RING_LOG_ASSERT_SVH
`define CHECKPOINT_RING_LOG_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define CRL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("checkpoint ring log: assertion failed");
// next-cycle implication
`define CRL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("checkpoint ring log: assertion failed");
`else
`define CRL_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CRL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[hdl/crl_pkg.sv]
// Shared types and constants for the checkpoint ring log.
// No dependencies; compiled first.
`default_nettype none

package crl_pkg;

    localparam int POS_W  = 32;
    localparam int SLOT_W = 4;
    localparam int OFF_W  = 6;
    localparam int SEED_W = 8;
    localparam int CMD_W  = 3;

    typedef logic [CMD_W-1:0]         t_cmd;
    typedef logic [POS_W-1:0]         t_pos;
    typedef logic signed [OFF_W-1:0]  t_offset;
    typedef logic [SEED_W-1:0]        t_seed;
    typedef logic [SLOT_W-1:0]        t_slot;

    localparam t_cmd CMD_START    = 3'd0;
    localparam t_cmd CMD_DONE     = 3'd1;
    localparam t_cmd CMD_STORE    = 3'd2;
    localparam t_cmd CMD_SCAN     = 3'd3;
    localparam t_cmd CMD_RETRIEVE = 3'd4;
    localparam t_cmd CMD_STATUS   = 3'd5;

    localparam t_pos POS_NONE = 32'hffff_ffff;

endpackage

`default_nettype wire

[hdl/crl_if.sv]
// Valid/ready channel interfaces for the checkpoint ring log.
// Depends on crl_pkg.
`default_nettype none

interface crl_in_if;
    logic               valid;
    logic               ready;
    crl_pkg::t_cmd      cmd;
    crl_pkg::t_pos      position;
    crl_pkg::t_offset   offset;
    crl_pkg::t_seed     seed;

    modport source (output valid, cmd, position, offset, seed, input ready);
    modport sink   (input valid, cmd, position, offset, seed, output ready);
endinterface

interface crl_out_if;
    logic               valid;
    logic               ready;
    crl_pkg::t_pos      value;
    crl_pkg::t_slot     newest_slot;
    crl_pkg::t_slot     oldest_slot;
    logic               working;

    modport source (output valid, value, newest_slot, oldest_slot, working, input ready);
    modport sink   (input valid, value, newest_slot, oldest_slot, working, output ready);
endinterface

`default_nettype wire

[hdl/checkpoint_ring_log.sv]
// Checkpoint ring log: a ring of ENTRIES positions with a working flag.
// Depends on crl_pkg, crl_if.sv and checkpoint_ring_log_assert.svh.
//
// Usage:
//   i_in carries one command transaction (start, done, store, scan, retrieve,
//   status); o_out returns exactly one result transaction per command with
//   the retrieved value (zero for non-retrieve commands), the newest and
//   oldest slots and the working flag.
//   Start, done, store and status pass from accept through the finish state
//   to the output register. Retrieve with an out-of-range offset does the
//   same; else it makes one read of the ring memory (registered read data).
//   Scan makes one memory read per cycle, which feeds a single compare
//   stage that tracks the largest and smallest nonzero entry.
//   i_in.ready is high only while the sequencer is idle, so one command is
//   in flight at a time.
//   The result sits in an output register; a finished command waits there
//   while the receiver stalls, and the next command is still accepted.
//   Reset clears the control state and marks every ring entry empty through
//   per-entry valid bits; no clearing pass is needed.
`default_nettype none

`include "checkpoint_ring_log_assert.svh"

module checkpoint_ring_log #(
    parameter int ENTRIES = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    crl_in_if.sink     i_in,
    crl_out_if.source  o_out
);
    import crl_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int AW = IW + 2;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_RREAD = 3'd2;
    localparam logic [2:0] S_RWAIT = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0]         r_state;
    logic [IW-1:0]      r_wslot;
    logic [IW-1:0]      r_newest;
    logic [IW-1:0]      r_oldest;
    logic               r_busy;
    logic [IW:0]        r_idx;
    logic               r_pend;
    logic [IW-1:0]      r_pidx;
    t_pos               r_hi;
    t_pos               r_lo;
    logic [IW-1:0]      r_addr;
    t_pos               r_value;
    logic [ENTRIES-1:0] r_valid;

    logic               r_out_valid;
    t_pos               r_out_value;
    t_slot              r_out_newest;
    t_slot              r_out_oldest;
    logic               r_out_working;

    t_pos               ring [ENTRIES];
    t_pos               r_rd_data;
    logic               r_rd_live;

    logic               in_fire;
    logic               mem_we;
    logic [IW-1:0]      rd_addr;
    logic [15:0]        seed_rem;
    logic [IW-1:0]      seed_mod;
    logic [IW-1:0]      wslot_next;

    logic signed [6:0]  k_ext;
    logic signed [6:0]  k_neg;
    logic               ret_neg;
    logic               ret_pos;
    logic [AW-1:0]      m_a;
    logic [AW-1:0]      sum_o;
    logic [AW-1:0]      sum_n;
    logic [AW-1:0]      sum_sel;
    logic [AW-1:0]      sum_mod;

    t_pos               rd_val;
    logic               upd_hi;
    logic               upd_lo;
    logic [IW-1:0]      scan_newest;
    logic [IW-1:0]      scan_next;
    logic               out_load;

    assign in_fire   = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign mem_we    = in_fire && (i_in.cmd == CMD_STORE);

    // seed mod ENTRIES by restoring subtraction, eight steps on a byte
    always_comb begin
        seed_rem = 16'(i_in.seed);
        for (int j = 7; j >= 0; j--) begin
            if (seed_rem >= (16'(ENTRIES) << j)) begin
                seed_rem = seed_rem - (16'(ENTRIES) << j);
            end
        end
        seed_mod = seed_rem[IW-1:0];
    end

    assign wslot_next = (r_wslot == IW'(ENTRIES - 1)) ? '0 : r_wslot + IW'(1);

    // retrieve slot: offset > 0 counts back from newest, < 0 forward from oldest
    always_comb begin
        k_ext   = {i_in.offset[OFF_W-1], i_in.offset};
        k_neg   = -k_ext;
        ret_neg = (k_ext < 0) && (int'(k_neg) <= ENTRIES);
        ret_pos = (k_ext > 0) && (int'(k_ext) <= ENTRIES);
        m_a     = ret_neg ? AW'(k_neg) : AW'(k_ext);
        sum_o   = AW'(r_oldest) + m_a - AW'(1);
        sum_n   = AW'(r_newest) + AW'(ENTRIES + 1) - m_a;
        sum_sel = ret_neg ? sum_o : sum_n;
        sum_mod = (sum_sel >= AW'(ENTRIES)) ? sum_sel - AW'(ENTRIES) : sum_sel;
    end

    // shared compare stage for the scan
    always_comb begin
        rd_val      = r_rd_live ? r_rd_data : '0;
        upd_hi      = r_pend && (rd_val != '0) && (rd_val > r_hi);
        upd_lo      = r_pend && (rd_val != '0) && (rd_val < r_lo);
        scan_newest = upd_hi ? r_pidx : r_newest;
        scan_next   = (scan_newest == IW'(ENTRIES - 1)) ? '0 : scan_newest + IW'(1);
    end

    always_comb begin
        if (r_state == S_SCAN && r_idx < (IW+1)'(ENTRIES)) begin
            rd_addr = r_idx[IW-1:0];
        end else begin
            rd_addr = r_addr;
        end
    end

    // ring memory, one write port and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            ring[r_wslot] <= i_in.position;
        end
        r_rd_data <= ring[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_rd_live <= 1'b0;
        end else begin
            if (mem_we) begin
                r_valid[r_wslot] <= 1'b1;
            end
            r_rd_live <= r_valid[rd_addr];
        end
    end

    assign out_load = (r_state == S_FIN) && (!r_out_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wslot  <= '0;
            r_newest <= '0;
            r_oldest <= '0;
            r_busy   <= 1'b0;
            r_idx    <= '0;
            r_pend   <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        unique case (i_in.cmd)
                            CMD_START: begin
                                r_busy  <= 1'b1;
                                r_wslot <= seed_mod;
                                r_value <= '0;
                                r_state <= S_FIN;
                            end
                            CMD_DONE: begin
                                r_busy  <= 1'b0;
                                r_value <= '0;
                                r_state <= S_FIN;
                            end
                            CMD_STORE: begin
                                r_wslot <= wslot_next;
                                r_value <= '0;
                                r_state <= S_FIN;
                            end
                            CMD_SCAN: begin
                                r_idx    <= '0;
                                r_pend   <= 1'b0;
                                r_hi     <= '0;
                                r_lo     <= POS_NONE;
                                r_newest <= '0;
                                r_oldest <= '0;
                                r_value  <= '0;
                                r_state  <= S_SCAN;
                            end
                            CMD_RETRIEVE: begin
                                if (ret_neg || ret_pos) begin
                                    r_addr  <= sum_mod[IW-1:0];
                                    r_state <= S_RREAD;
                                end else begin
                                    r_value <= POS_NONE;
                                    r_state <= S_FIN;
                                end
                            end
                            default: begin
                                r_value <= '0;
                                r_state <= S_FIN;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (upd_hi) begin
                        r_hi     <= rd_val;
                        r_newest <= r_pidx;
                    end
                    if (upd_lo) begin
                        r_lo     <= rd_val;
                        r_oldest <= r_pidx;
                    end
                    r_pidx <= r_idx[IW-1:0];
                    if (r_idx < (IW+1)'(ENTRIES)) begin
                        r_pend <= 1'b1;
                        r_idx  <= r_idx + (IW+1)'(1);
                    end else begin
                        // last entry compared this cycle
                        r_pend  <= 1'b0;
                        r_wslot <= scan_next;
                        r_state <= S_FIN;
                    end
                end
                S_RREAD: begin
                    r_state <= S_RWAIT;
                end
                S_RWAIT: begin
                    r_value <= (r_rd_live && r_rd_data != '0) ? r_rd_data : POS_NONE;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // output register: hold the result until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_value   <= r_value;
            r_out_newest  <= SLOT_W'(r_newest);
            r_out_oldest  <= SLOT_W'(r_oldest);
            r_out_working <= r_busy;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.value       = r_out_value;
    assign o_out.newest_slot = r_out_newest;
    assign o_out.oldest_slot = r_out_oldest;
    assign o_out.working     = r_out_working;

    `CRL_ASSERT_NEXT(a_start_sets_busy, i_clk, i_rst_n, in_fire && i_in.cmd == CMD_START, r_busy)
    `CRL_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, in_fire, !i_in.ready)
    `CRL_ASSERT_IMPL(a_wslot_range, i_clk, i_rst_n, 1'b1, int'(r_wslot) < ENTRIES)
    `CRL_ASSERT_IMPL(a_newest_range, i_clk, i_rst_n, 1'b1, int'(r_newest) < ENTRIES)
    `CRL_ASSERT_IMPL(a_oldest_range, i_clk, i_rst_n, 1'b1, int'(r_oldest) < ENTRIES)

endmodule

`default_nettype wire
